[hw/rtl/puf_pkg.sv]
// Shared types and constants for the persistent union-find unit.
`timescale 1ns / 1ps
package puf_pkg;
    localparam int NODES   = 1024;
    localparam int NODE_W  = 10;
    localparam int TIME_W  = 16;
    localparam int SIZE_W  = 11;
    localparam int HPTR_W  = 11;

    typedef enum logic [1:0] {
        OP_UNITE = 2'd0,
        OP_SAME  = 2'd1,
        OP_SIZE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        DC_IDLE,
        DC_CLEAR,
        DC_LOAD,
        DC_FIND_START,
        DC_FIND_STEP,
        DC_FIND_END,
        DC_SIZE_START,
        DC_SIZE_LATEST,
        DC_SIZE_STEP,
        DC_SIZE_END,
        DC_LINK,
        DC_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel;       // 0: node_a side, 1: node_b side
        logic   unit;      // size result is a singleton
        logic   save_lat;  // keep the latest-entry pointer of this root
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic find_stop;
        logic lat_zero;
        logic hist_hit;
        logic prev_zero;
        logic roots_eq;
        t_op  op;
    } t_status;
endpackage

[hw/rtl/persistent_union_find_unit.sv]
// Top level of the partially persistent union-find unit.
`timescale 1ns / 1ps
// Usage:
//   Present an item on i_operation, i_node_a, i_node_b and i_query_time with
//   i_start high; it is taken at the clock edge where o_busy is low.
//   Operations: unite two nodes, same-set query at a past turn, set size
//   query at a past turn. Node indexes past the last node clamp to it.
//   Each item yields exactly one result, shown for one cycle with o_valid
//   high on o_answer_flag, o_set_size and o_root_node; the receiver must
//   take it then, it cannot stall the unit.
//   Steps after the accepting edge: a root walk (node_a, plus node_b on unite
//   and same), a size walk (node_a, plus node_b on a merging unite), a link
//   on a merge and a register for the result; the unused opcode skips the
//   walks and the link.
//   A root walk climbs one link per cycle on the single read port of the
//   parent memory; a size walk reads one history entry per cycle. One item
//   is processed at a time; o_busy falls on the cycle the result appears.
//   Reset: after i_rst_n is released, a clearing pass over all 1024 nodes makes
//   every node its own root and empties the history pointers; o_busy stays
//   high for its whole length.
module persistent_union_find_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_operation,
    input  logic [puf_pkg::NODE_W-1:0]  i_node_a,
    input  logic [puf_pkg::NODE_W-1:0]  i_node_b,
    input  logic [puf_pkg::TIME_W-1:0]  i_query_time,
    output logic                        o_valid,
    output logic                        o_answer_flag,
    output logic [puf_pkg::SIZE_W-1:0]  o_set_size,
    output logic [puf_pkg::NODE_W-1:0]  o_root_node
);
    import puf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence the walks.
    puf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Hold the stores and walk registers.
    puf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_query_time  (i_query_time),
        .o_valid       (o_valid),
        .o_answer_flag (o_answer_flag),
        .o_set_size    (o_set_size),
        .o_root_node   (o_root_node)
    );
endmodule

[hw/rtl/puf_ctrl.sv]
// Sequencer that steps the datapath through walks and links.
`timescale 1ns / 1ps
module puf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  puf_pkg::t_status i_status,
    output puf_pkg::t_cmd    o_cmd
);
    import puf_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FA, ST_FB, ST_FCHK, ST_SA, ST_SB,
        ST_SLAT, ST_SCHK, ST_LINK, ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '{op: DC_IDLE, sel: r_sel, unit: 1'b0, save_lat: 1'b0};
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = DC_CLEAR;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DC_LOAD;
                    n_state  = ST_FA;
                end
            end
            ST_FA: begin
                if (i_status.op == OP_NONE) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.op  = DC_FIND_START;
                    o_cmd.sel = 1'b0;
                    n_sel     = 1'b0;
                    n_state   = ST_FCHK;
                end
            end
            ST_FB: begin
                o_cmd.op  = DC_FIND_START;
                o_cmd.sel = 1'b1;
                n_sel     = 1'b1;
                n_state   = ST_FCHK;
            end
            ST_FCHK: begin
                if (i_status.find_stop) begin
                    o_cmd.op = DC_FIND_END;
                    if (r_sel || i_status.op == OP_SIZE) n_state = ST_SA;
                    else n_state = ST_FB;
                end else begin
                    o_cmd.op = DC_FIND_STEP;
                end
            end
            ST_SA: begin
                o_cmd.op  = DC_SIZE_START;
                o_cmd.sel = 1'b0;
                n_sel     = 1'b0;
                n_state   = ST_SLAT;
            end
            ST_SB: begin
                o_cmd.op  = DC_SIZE_START;
                o_cmd.sel = 1'b1;
                n_sel     = 1'b1;
                n_state   = ST_SLAT;
            end
            ST_SLAT: begin
                o_cmd.save_lat = 1'b1;
                if (i_status.lat_zero) begin
                    o_cmd.op   = DC_SIZE_END;
                    o_cmd.unit = 1'b1;
                end else begin
                    o_cmd.op = DC_SIZE_LATEST;
                    n_state  = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (i_status.hist_hit) begin
                    o_cmd.op = DC_SIZE_END;
                end else if (i_status.prev_zero) begin
                    o_cmd.op   = DC_SIZE_END;
                    o_cmd.unit = 1'b1;
                end else begin
                    o_cmd.op = DC_SIZE_STEP;
                end
            end
            ST_LINK: begin
                o_cmd.op = DC_LINK;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.op = DC_OUT;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // Route the end of a size walk to the next step.
        if (o_cmd.op == DC_SIZE_END) begin
            if (r_sel) n_state = ST_LINK;
            else if (i_status.op == OP_UNITE && !i_status.roots_eq) n_state = ST_SB;
            else n_state = ST_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DC_LOAD) |-> (r_state == ST_IDLE && i_start))
        else $error("load issued outside idle");
    a_link_after_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINK) |-> $past(r_sel))
        else $error("link without second size walk");
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> (r_state != ST_CLEAR))
        else $error("clear pass re-entered");
endmodule

[hw/rtl/puf_dp.sv]
// Datapath: node, stamp and history memories with walk registers.
`timescale 1ns / 1ps
module puf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  puf_pkg::t_cmd                i_cmd,
    output puf_pkg::t_status             o_status,
    input  logic [1:0]                   i_operation,
    input  logic [puf_pkg::NODE_W-1:0]   i_node_a,
    input  logic [puf_pkg::NODE_W-1:0]   i_node_b,
    input  logic [puf_pkg::TIME_W-1:0]   i_query_time,
    output logic                         o_valid,
    output logic                         o_answer_flag,
    output logic [puf_pkg::SIZE_W-1:0]   o_set_size,
    output logic [puf_pkg::NODE_W-1:0]   o_root_node
);
    import puf_pkg::*;

    logic [NODE_W-1:0] m_par   [NODES];
    logic [TIME_W-1:0] m_stamp [NODES];
    logic [HPTR_W-1:0] m_lat   [NODES];
    logic [TIME_W-1:0] m_ht    [NODES];
    logic [SIZE_W-1:0] m_hs    [NODES];
    logic [HPTR_W-1:0] m_hp    [NODES];

    t_op               r_op;
    logic [NODE_W-1:0] r_a, r_b, r_x, r_ra, r_rb, r_keep;
    logic [TIME_W-1:0] r_tm, r_turn;
    logic              r_all;
    logic [SIZE_W-1:0] r_sa, r_sb;
    logic [HPTR_W-1:0] r_la, r_lb, r_count;
    logic [NODE_W:0]   r_clr;
    logic [NODE_W-1:0] r_par_q;
    logic [TIME_W-1:0] r_stamp_q, r_ht_q;
    logic [HPTR_W-1:0] r_lat_q, r_hp_q;
    logic [SIZE_W-1:0] r_hs_q;
    logic              r_valid, r_flag;
    logic [SIZE_W-1:0] r_size;
    logic [NODE_W-1:0] r_root;

    logic [NODE_W-1:0] a_cl, b_cl, par_ra, par_wa, par_wd, lat_ra, lat_wa, keep, child;
    logic [NODE_W-1:0] h_ra;
    logic [HPTR_W-1:0] lat_wd;
    logic              par_we, lat_we, link_we;
    logic [SIZE_W-1:0] sz_val;

    assign a_cl = (i_node_a >= NODE_W'(NODES - 1)) ? NODE_W'(NODES - 1) : i_node_a;
    assign b_cl = (i_node_b >= NODE_W'(NODES - 1)) ? NODE_W'(NODES - 1) : i_node_b;

    assign keep  = (r_sb > r_sa) ? r_rb : r_ra;
    assign child = (r_sb > r_sa) ? r_ra : r_rb;

    always_comb begin
        par_ra  = r_par_q;
        if (i_cmd.op == DC_FIND_START) par_ra = i_cmd.sel ? r_b : r_a;
        lat_ra  = i_cmd.sel ? r_rb : r_ra;
        h_ra    = (i_cmd.op == DC_SIZE_LATEST) ? NODE_W'(r_lat_q - 1'b1)
                                               : NODE_W'(r_hp_q - 1'b1);
        link_we = (i_cmd.op == DC_LINK);
        par_we  = (i_cmd.op == DC_CLEAR) || link_we;
        lat_we  = (i_cmd.op == DC_CLEAR) || (link_we && r_count < HPTR_W'(NODES));
        par_wa  = link_we ? child : r_clr[NODE_W-1:0];
        par_wd  = link_we ? keep  : r_clr[NODE_W-1:0];
        lat_wa  = link_we ? keep  : r_clr[NODE_W-1:0];
        lat_wd  = link_we ? (r_count + 1'b1) : '0;
        sz_val  = i_cmd.unit ? SIZE_W'(1) : r_hs_q;
    end

    always_ff @(posedge i_clk) begin
        if (par_we) m_par[par_wa] <= par_wd;
        if (link_we) m_stamp[child] <= r_turn;
        r_par_q   <= m_par[par_ra];
        r_stamp_q <= m_stamp[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lat_we) m_lat[lat_wa] <= lat_wd;
        r_lat_q <= m_lat[lat_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we && r_count < HPTR_W'(NODES)) begin
            m_ht[r_count[NODE_W-1:0]] <= r_turn;
            m_hs[r_count[NODE_W-1:0]] <= SIZE_W'(r_sa + r_sb);
            m_hp[r_count[NODE_W-1:0]] <= (r_sb > r_sa) ? r_lb : r_la;
        end
        r_ht_q <= m_ht[h_ra];
        r_hs_q <= m_hs[h_ra];
        r_hp_q <= m_hp[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_turn  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_op    <= OP_NONE;
        end else begin
            r_valid <= (i_cmd.op == DC_OUT);
            unique case (i_cmd.op)
                DC_CLEAR: r_clr <= r_clr + 1'b1;
                DC_LOAD: begin
                    r_op  <= t_op'(i_operation);
                    r_a   <= a_cl;
                    r_b   <= b_cl;
                    r_tm  <= i_query_time;
                    r_all <= (t_op'(i_operation) == OP_UNITE);
                    if (t_op'(i_operation) == OP_UNITE && r_turn != '1)
                        r_turn <= r_turn + 1'b1;
                end
                DC_FIND_START: r_x <= i_cmd.sel ? r_b : r_a;
                DC_FIND_STEP:  r_x <= r_par_q;
                DC_FIND_END: begin
                    if (i_cmd.sel) r_rb <= r_x;
                    else r_ra <= r_x;
                end
                DC_SIZE_END: begin
                    if (i_cmd.sel) r_sb <= sz_val;
                    else r_sa <= sz_val;
                end
                DC_LINK: begin
                    r_keep <= keep;
                    if (r_count < HPTR_W'(NODES)) r_count <= r_count + 1'b1;
                end
                DC_OUT: begin
                    unique case (r_op)
                        OP_UNITE: begin
                            r_flag <= (r_ra != r_rb);
                            r_size <= (r_ra != r_rb) ? SIZE_W'(r_sa + r_sb) : r_sa;
                            r_root <= (r_ra != r_rb) ? r_keep : r_ra;
                        end
                        OP_SAME: begin
                            r_flag <= (r_ra == r_rb);
                            r_size <= r_sa;
                            r_root <= r_ra;
                        end
                        OP_SIZE: begin
                            r_flag <= 1'b0;
                            r_size <= r_sa;
                            r_root <= r_ra;
                        end
                        default: begin
                            r_flag <= 1'b0;
                            r_size <= '0;
                            r_root <= '0;
                        end
                    endcase
                end
                default: ;
            endcase
            if (i_cmd.save_lat) begin
                if (i_cmd.sel) r_lb <= r_lat_q;
                else r_la <= r_lat_q;
            end
        end
    end

    always_comb begin
        o_status.clr_last  = (r_clr[NODE_W-1:0] == NODE_W'(NODES - 1));
        o_status.find_stop = (r_par_q == r_x) || (!r_all && r_stamp_q > r_tm);
        o_status.lat_zero  = (r_lat_q == '0);
        o_status.hist_hit  = r_all || (r_ht_q <= r_tm);
        o_status.prev_zero = (r_hp_q == '0);
        o_status.roots_eq  = (r_ra == r_rb);
        o_status.op        = r_op;
    end

    assign o_valid       = r_valid;
    assign o_answer_flag = r_flag;
    assign o_set_size    = r_size;
    assign o_root_node   = r_root;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HPTR_W'(NODES))
        else $error("history count overflow");
    a_turn_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_turn >= $past(r_turn))
        else $error("turn counter went back");
    a_link_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DC_LINK) |-> (r_ra != r_rb))
        else $error("link of a root to itself");
endmodule

[bench/persistent_union_find_unit_tb.sv]
// Self-checking testbench for the persistent union-find unit.
`timescale 1ns / 1ps
module persistent_union_find_unit_tb;
    import puf_pkg::*;

    localparam int TURN_MAX = (1 << TIME_W) - 1;

    typedef struct {
        logic              flag;
        logic [SIZE_W-1:0] size;
        logic [NODE_W-1:0] root;
    } t_answer;

    // Scoreboard: holds its own copy of the forest and the size history,
    // predicts the answer of every accepted item and checks results in order.
    class forest_scoreboard;
        int unsigned parent[NODES];
        int unsigned stamp[NODES];
        int unsigned turn;
        int unsigned hist_turn[NODES];
        int unsigned hist_size[NODES];
        int unsigned hist_prev[NODES];
        int unsigned latest[NODES];
        int unsigned hist_cnt;
        t_answer     pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < NODES; i++) begin
                parent[i] = i;
                latest[i] = 0;
            end
            turn = 0;
            hist_cnt = 0;
            errors = 0;
        endfunction

        function int unsigned root_at(longint unsigned tm, int unsigned x);
            for (int s = 0; s < NODES; s++) begin
                if (parent[x] == x || stamp[x] > tm) break;
                x = parent[x];
            end
            return x;
        endfunction

        function int unsigned size_at(longint unsigned tm, int unsigned r);
            int unsigned p;
            p = latest[r];
            for (int s = 0; s < NODES && p != 0 && p <= hist_cnt; s++) begin
                if (hist_turn[p-1] <= tm) return hist_size[p-1];
                p = hist_prev[p-1];
            end
            return 1;
        endfunction

        // Note an accepted item and queue the answer it should produce.
        function void note_item(logic [1:0] op, int unsigned a, int unsigned b,
                                 longint unsigned tm);
            t_answer     ans;
            int unsigned ra, rb, sa, sb, keep, child;
            ans = '{1'b0, '0, '0};
            if (op == OP_UNITE) begin
                ra = root_at(64'hFFFF_FFFF, a);
                rb = root_at(64'hFFFF_FFFF, b);
                if (turn < TURN_MAX) turn++;
                if (ra == rb) begin
                    ans.root = NODE_W'(ra);
                    ans.size = SIZE_W'(size_at(64'hFFFF_FFFF, ra));
                end else begin
                    sa = size_at(64'hFFFF_FFFF, ra);
                    sb = size_at(64'hFFFF_FFFF, rb);
                    keep = ra;
                    child = rb;
                    if (sb > sa) begin
                        keep = rb;
                        child = ra;
                    end
                    parent[child] = keep;
                    stamp[child] = turn;
                    if (hist_cnt < NODES) begin
                        hist_turn[hist_cnt] = turn;
                        hist_size[hist_cnt] = sa + sb;
                        hist_prev[hist_cnt] = latest[keep];
                        hist_cnt++;
                        latest[keep] = hist_cnt;
                    end
                    ans.flag = 1'b1;
                    ans.root = NODE_W'(keep);
                    ans.size = SIZE_W'(sa + sb);
                end
            end else if (op == OP_SAME) begin
                ra = root_at(tm, a);
                rb = root_at(tm, b);
                ans.flag = (ra == rb);
                ans.root = NODE_W'(ra);
                ans.size = SIZE_W'(size_at(tm, ra));
            end else if (op == OP_SIZE) begin
                ra = root_at(tm, a);
                ans.root = NODE_W'(ra);
                ans.size = SIZE_W'(size_at(tm, ra));
            end
            pending.insert(pending.size(), ans);
        endfunction

        function void check_result(logic flag, logic [SIZE_W-1:0] size,
                                   logic [NODE_W-1:0] root);
            t_answer exp_ans;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            exp_ans = pending.pop_front();
            if (flag !== exp_ans.flag) begin
                $error("answer_flag expected %0d actual %0d", exp_ans.flag, flag);
                errors++;
            end
            if (size !== exp_ans.size) begin
                $error("set_size expected %0d actual %0d", exp_ans.size, size);
                errors++;
            end
            if (root !== exp_ans.root) begin
                $error("root_node expected %0d actual %0d", exp_ans.root, root);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        operation = '0;
    logic [NODE_W-1:0] node_a = '0;
    logic [NODE_W-1:0] node_b = '0;
    logic [TIME_W-1:0] query_time = '0;
    logic              busy, valid, answer_flag;
    logic [SIZE_W-1:0] set_size;
    logic [NODE_W-1:0] root_node;

    forest_scoreboard sb = new();

    always #1 clk = ~clk;

    persistent_union_find_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_operation  (operation),
        .i_node_a     (node_a),
        .i_node_b     (node_b),
        .i_query_time (query_time),
        .o_valid      (valid),
        .o_answer_flag(answer_flag),
        .o_set_size   (set_size),
        .o_root_node  (root_node)
    );

    // Sample results at the edge that accepts them.
    always @(posedge clk) begin
        if (rst_n && valid) sb.check_result(answer_flag, set_size, root_node);
    end

    // Present one item, hold it until taken, then optionally drop start for a random gap.
    task automatic send_item(logic [1:0] op, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b, logic [TIME_W-1:0] tm);
        int gap;
        operation <= op;
        node_a <= a;
        node_b <= b;
        query_time <= tm;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(op, a, b, tm);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
              ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [NODE_W-1:0] pick_node(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return {NODE_W{1'b1}};
        if (r == 1) return NODE_W'($urandom());
        return NODE_W'($urandom_range(0, span - 1));
    endfunction

    initial begin
        int unsigned span, k;
        logic [1:0]  op;
        sb.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every operation, the unused opcode.
        send_item(OP_SIZE, 0, 0, 0);
        send_item(OP_SAME, 0, 1023, 16'hFFFF);
        send_item(OP_UNITE, 0, 1023, 0);
        send_item(OP_UNITE, 1023, 0, 0);
        send_item(OP_UNITE, 1, 2, 0);
        send_item(OP_UNITE, 2, 0, 0);
        send_item(OP_UNITE, 3, 3, 0);
        send_item(OP_SAME, 1, 1023, 0);
        send_item(OP_SAME, 1, 1023, 3);
        send_item(OP_SAME, 1, 1023, 16'hFFFF);
        send_item(OP_SIZE, 1, 0, 1);
        send_item(OP_SIZE, 1, 0, 3);
        send_item(OP_SIZE, 1023, 0, 16'hFFFF);
        send_item(OP_NONE, 10'h3FF, 10'h3FF, 16'hFFFF);
        send_item(OP_NONE, 0, 0, 0);
        send_item(OP_SAME, 10'h2AA, 10'h155, 16'hAAAA);
        send_item(OP_SIZE, 10'h155, 10'h2AA, 16'h5555);

        // Random: grow a forest on a small range first, then widen it.
        for (int n = 0; n < 1900; n++) begin
            span = (n < 900) ? 32 : 1024;
            k = $urandom_range(0, 99);
            op = (k < 45) ? OP_UNITE : (k < 70) ? OP_SAME : (k < 96) ? OP_SIZE : OP_NONE;
            send_item(op, pick_node(span), pick_node(span),
                      ($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) :
                      TIME_W'($urandom_range(0, sb.turn + 2)));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
